/* rtl/assert_macros.svh */
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every rising edge outside reset.
`define SKCD_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
// Condition that implies another in the same cycle.
`define SKCD_IMPLIES(lbl, clk_s, rst_s, cond, conseq, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |-> (conseq)) \
    else $error(msg);
`else
`define SKCD_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define SKCD_IMPLIES(lbl, clk_s, rst_s, cond, conseq, msg)
`endif
`endif

/* rtl/skcd_pkg.sv */
`default_nettype none
package skcd_pkg;

  // Default table size and configuration reset values.
  localparam int CAPACITY_DEF = 2048;
  localparam logic [11:0] BAL_THR_RST   = 12'd484;
  localparam logic [31:0] INTERVAL_RST  = 32'd484;
  localparam logic [11:0] SWEEP_MIN_RST = 12'd1024;

  // Command codes of the input item.
  localparam logic [1:0] CMD_ACCESS   = 2'd0;
  localparam logic [1:0] CMD_FREE     = 2'd1;
  localparam logic [1:0] CMD_FREE_ALL = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BAL_THR   = 2'd0;
  localparam logic [1:0] CFG_INTERVAL  = 2'd1;
  localparam logic [1:0] CFG_SWEEP_MIN = 2'd2;

  typedef enum logic [1:0] {
    K_ACCESS, K_FREE, K_FREE_ALL, K_INVALID
  } kind_t;

  typedef enum logic [2:0] {
    ST_HIT, ST_MISMATCH, ST_INSERTED, ST_LOAD_FAIL,
    ST_FULL, ST_FREED, ST_NOT_FOUND, ST_INVALID
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SCMP, S_PCHK, S_DEL_RD, S_DEL_WR, S_INS_RD, S_INS_WR,
    S_BAL, S_SW_RD, S_SW_WR, S_DONE
  } bk_state_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] key;
    logic [7:0]  etype;
    logic        load_ok;
  } q_item_t;

  // Queue head as seen by the back part.
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic        refb;
    logic [7:0]  etype;
    logic [31:0] key;
  } entry_t;

  typedef struct packed {
    logic [11:0] bal_thr;
    logic [31:0] interval;
    logic [11:0] sweep_min;
  } cfg_t;

endpackage
`default_nettype wire

/* rtl/skcd_ram.sv */
`default_nettype none
module skcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/skcd_front.sv */
`default_nettype none
module skcd_front (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  [1:0]         command_i,
  input  wire  [31:0]        key_i,
  input  wire  [7:0]         etype_i,
  input  wire                load_ok_i,
  output skcd_pkg::q_head_t  head_o,
  input  wire                pop_i
);
  import skcd_pkg::*;

  q_item_t    slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  q_item_t    cls;
  logic       push;

  // Classify the command so that the back part needs no decoding.
  always_comb begin
    cls.key     = key_i;
    cls.etype   = etype_i;
    cls.load_ok = load_ok_i;
    case (command_i)
      CMD_FREE_ALL: cls.kind = K_FREE_ALL;
      CMD_ACCESS:   cls.kind = (key_i == 32'd0) ? K_INVALID : K_ACCESS;
      CMD_FREE:     cls.kind = (key_i == 32'd0) ? K_INVALID : K_FREE;
      default:      cls.kind = K_INVALID;
    endcase
  end

  assign in_ready_o = (cnt_r != 2'd2);
  assign push       = in_valid_i && in_ready_o;

  // Two-entry queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_i ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

  assign head_o.valid = (cnt_r != 2'd0);
  assign head_o.item  = slot_r[rd_ptr_r];

endmodule
`default_nettype wire

/* rtl/skcd_back.sv */
`default_nettype none
module skcd_back #(
  parameter int CAPACITY = skcd_pkg::CAPACITY_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  skcd_pkg::cfg_t    cfg_i,
  input  skcd_pkg::q_head_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [2:0]        status_o,
  output logic [10:0]       position_o,
  output logic [11:0]       entry_count_o,
  output logic              swept_o
);
  import skcd_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  bk_state_t        state_r, state_nxt;
  q_item_t          item_r, item_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, p_r, p_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, w_r, w_nxt;
  status_t          st_r, st_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             sw_r, sw_nxt;
  logic             ov_r, ov_nxt;
  status_t          ost_r;
  logic [CNT_W-1:0] opos_r, ocnt_r;
  logic             osw_r, load_out;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata, rdata;
  logic [CNT_W-1:0] mid;
  logic [31:0]      acc_inc;

  skcd_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign acc_inc = acc_r + 32'd1;

  // Sequencer: search, shift, balance check and sweep over the table memory.
  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    held_nxt  = held_r;
    acc_nxt   = acc_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    p_nxt     = p_r;
    i_nxt     = i_r;
    w_nxt     = w_r;
    st_nxt    = st_r;
    pos_nxt   = pos_r;
    sw_nxt    = sw_r;
    pop_o     = 1'b0;
    load_out  = 1'b0;
    we        = 1'b0;
    waddr     = i_r[IDX_W-1:0];
    wdata     = rdata;
    raddr     = i_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o    = 1'b1;
          item_nxt = head_i.item;
          pos_nxt  = '0;
          sw_nxt   = 1'b0;
          case (head_i.item.kind)
            K_FREE_ALL: begin
              held_nxt  = '0;
              acc_nxt   = '0;
              st_nxt    = ST_FREED;
              state_nxt = S_DONE;
            end
            K_INVALID: begin
              st_nxt    = ST_INVALID;
              state_nxt = S_DONE;
            end
            default: begin
              lo_nxt    = '0;
              hi_nxt    = held_r;
              state_nxt = S_SRCH;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          raddr     = mid[IDX_W-1:0];
          p_nxt     = mid;
          state_nxt = S_SCMP;
        end else begin
          raddr     = lo_r[IDX_W-1:0];
          p_nxt     = lo_r;
          state_nxt = S_PCHK;
        end
      end
      S_SCMP: begin
        if (rdata.key < item_r.key) begin
          lo_nxt = p_r + ONE_C;
        end else begin
          hi_nxt = p_r;
        end
        state_nxt = S_SRCH;
      end
      S_PCHK: begin
        if ((p_r < held_r) && (rdata.key == item_r.key)) begin
          pos_nxt = p_r;
          if (item_r.kind == K_FREE) begin
            st_nxt    = ST_FREED;
            i_nxt     = p_r;
            state_nxt = S_DEL_RD;
          end else if (rdata.etype == item_r.etype) begin
            we         = 1'b1;
            waddr      = p_r[IDX_W-1:0];
            wdata      = rdata;
            wdata.refb = 1'b1;
            st_nxt     = ST_HIT;
            state_nxt  = S_BAL;
          end else begin
            st_nxt    = ST_MISMATCH;
            state_nxt = S_BAL;
          end
        end else if (item_r.kind == K_FREE) begin
          st_nxt    = ST_NOT_FOUND;
          state_nxt = S_DONE;
        end else if (held_r >= CAP_C) begin
          st_nxt    = ST_FULL;
          state_nxt = S_DONE;
        end else if (!item_r.load_ok) begin
          st_nxt    = ST_LOAD_FAIL;
          state_nxt = S_DONE;
        end else begin
          i_nxt     = held_r;
          state_nxt = S_INS_RD;
        end
      end
      // Close the gap: entry i+1 moves down to i.
      S_DEL_RD: begin
        if ((i_r + ONE_C) < held_r) begin
          raddr     = IDX_W'(i_r + ONE_C);
          state_nxt = S_DEL_WR;
        end else begin
          held_nxt  = held_r - ONE_C;
          state_nxt = S_DONE;
        end
      end
      S_DEL_WR: begin
        we        = 1'b1;
        i_nxt     = i_r + ONE_C;
        state_nxt = S_DEL_RD;
      end
      // Open a gap: entry i-1 moves up to i, then the new key lands at p.
      S_INS_RD: begin
        if (i_r > p_r) begin
          raddr     = IDX_W'(i_r - ONE_C);
          state_nxt = S_INS_WR;
        end else begin
          we          = 1'b1;
          waddr       = p_r[IDX_W-1:0];
          wdata.key   = item_r.key;
          wdata.etype = item_r.etype;
          wdata.refb  = 1'b1;
          held_nxt    = held_r + ONE_C;
          st_nxt      = ST_INSERTED;
          pos_nxt     = p_r;
          state_nxt   = S_BAL;
        end
      end
      S_INS_WR: begin
        we        = 1'b1;
        i_nxt     = i_r - ONE_C;
        state_nxt = S_INS_RD;
      end
      S_BAL: begin
        state_nxt = S_DONE;
        if (32'(held_r) > 32'(cfg_i.bal_thr)) begin
          acc_nxt = acc_inc;
          if (acc_inc > cfg_i.interval) begin
            acc_nxt = '0;
            if (32'(held_r) >= 32'(cfg_i.sweep_min)) begin
              sw_nxt    = 1'b1;
              i_nxt     = '0;
              w_nxt     = '0;
              state_nxt = S_SW_RD;
            end
          end
        end
      end
      // Second-chance sweep: keep referenced entries, clear their bit.
      S_SW_RD: begin
        if (i_r < held_r) begin
          state_nxt = S_SW_WR;
        end else begin
          held_nxt  = w_r;
          state_nxt = S_DONE;
        end
      end
      S_SW_WR: begin
        if (rdata.refb) begin
          we         = 1'b1;
          waddr      = w_r[IDX_W-1:0];
          wdata.refb = 1'b0;
          w_nxt      = w_r + ONE_C;
        end
        i_nxt     = i_r + ONE_C;
        state_nxt = S_SW_RD;
      end
      S_DONE: begin
        if (!ov_r || out_ready_i) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register holds the result until it is taken.
  always_comb begin
    ov_nxt = ov_r;
    if (out_ready_i) begin
      ov_nxt = 1'b0;
    end
    if (load_out) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= '0;
      acc_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      acc_r   <= acc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    p_r    <= p_nxt;
    i_r    <= i_nxt;
    w_r    <= w_nxt;
    st_r   <= st_nxt;
    pos_r  <= pos_nxt;
    sw_r   <= sw_nxt;
    if (load_out) begin
      ost_r  <= st_r;
      opos_r <= pos_r;
      ocnt_r <= held_r;
      osw_r  <= sw_r;
    end
  end

  assign out_valid_o   = ov_r;
  assign status_o      = ost_r;
  assign position_o    = 11'(opos_r);
  assign entry_count_o = 12'(ocnt_r);
  assign swept_o       = osw_r;

endmodule
`default_nettype wire

/* rtl/sorted_key_cache_directory_unit.sv */
// Channel | Direction | Handshake             | Payload
// in_     | input     | in_tvalid/in_tready   | tuser command, tdata key/type/load_ok
// out_    | output    | out_tvalid/out_tready | tuser status, tdata position/count/swept
// cfg_    | input     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// A search is a binary search on the table memory; a hit marks its entry, a free that finds its key
// closes the gap and an insert opens one, moving entries one at a time, and a sweep reads every held entry.
// Free all and invalid items leave the table memory alone. The memory has a single read port.
// Reset (synchronous, rst_n low) empties the table and loads the register defaults.
// A two-item queue keeps accepting, until it is full, while the back part works or a result is stalled.
`default_nettype none
`include "assert_macros.svh"
module sorted_key_cache_directory_unit #(
  parameter int CAPACITY = skcd_pkg::CAPACITY_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,   // key[31:0], entry_type[39:32], load_ok[40], zero pad
  input  wire  [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // position[10:0], entry_count[22:11], swept[23]
  output logic [2:0]  out_tuser,  // status[2:0]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import skcd_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  q_head_t     head;
  logic        pop;
  logic [10:0] position;
  logic [11:0] entry_count;
  logic        swept;

  // Configuration registers, written whenever the port offers a write; index 3 is ignored.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_BAL_THR:   cfg_nxt.bal_thr   = cfg_data[11:0];
        CFG_INTERVAL:  cfg_nxt.interval  = cfg_data;
        CFG_SWEEP_MIN: cfg_nxt.sweep_min = cfg_data[11:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bal_thr   <= BAL_THR_RST;
      cfg_r.interval  <= INTERVAL_RST;
      cfg_r.sweep_min <= SWEEP_MIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  skcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_tvalid),
    .in_ready_o (in_tready),
    .command_i  (in_tuser),
    .key_i      (in_tdata[31:0]),
    .etype_i    (in_tdata[39:32]),
    .load_ok_i  (in_tdata[40]),
    .head_o     (head),
    .pop_i      (pop)
  );

  skcd_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_i         (cfg_r),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_tvalid),
    .out_ready_i   (out_tready),
    .status_o      (out_tuser),
    .position_o    (position),
    .entry_count_o (entry_count),
    .swept_o       (swept)
  );

  assign out_tdata = {swept, entry_count, position};

  // A sweep only follows a hit, a mismatch or an insert.
  `SKCD_IMPLIES(a_swept_status, clk, rst_n, out_tvalid && out_tdata[23], (out_tuser == ST_HIT) || (out_tuser == ST_MISMATCH) || (out_tuser == ST_INSERTED), "sweep reported with a wrong status")
  // Statuses without an entry report position zero.
  `SKCD_IMPLIES(a_pos_zero, clk, rst_n, out_tvalid && ((out_tuser == ST_INVALID) || (out_tuser == ST_NOT_FOUND) || (out_tuser == ST_FULL) || (out_tuser == ST_LOAD_FAIL)), out_tdata[10:0] == 11'd0, "position set without an entry")
  // The reported count never exceeds the table size.
  `SKCD_IMPLIES(a_count_cap, clk, rst_n, out_tvalid, 32'(out_tdata[22:11]) <= CAPACITY, "entry count above capacity")

endmodule
`default_nettype wire
